// File: hdl/unix_seconds_to_civil_date_unit_macros.svh
// ============================================================================
// Assertion macros for the civil date unit
// Clocked implication checks that compile away when SYNTHESIS is defined.
// ============================================================================
`ifndef UNIX_SECONDS_TO_CIVIL_DATE_UNIT_MACROS_SVH
`define UNIX_SECONDS_TO_CIVIL_DATE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define UCD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define UCD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UCD_ASSERT_IMP(label, ante, cons, msg)
`define UCD_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// File: hdl/ucd_pkg.sv
// ============================================================================
// Civil date unit package
// Constants and types shared by the Unix time to calendar date converter.
// ============================================================================
`default_nettype none

package ucd_pkg;

    // Valid span: 0000-01-01T00:00:00 up to but not including 10000-01-01.
    localparam logic signed [63:0] LOW_LIMIT_SECS  = -64'sd62167219200;
    localparam logic signed [63:0] HIGH_LIMIT_SECS = 64'sd253402300800;
    // Seconds from 0000-01-01 to the epoch; a whole number of days.
    localparam logic [38:0] YEAR0_OFFSET = 39'd62167219200;

    // One day is 128 * 675 seconds.
    localparam logic [9:0] DAY_ODD_FACTOR = 10'd675;
    localparam int DAY_RCP_K = 42;
    localparam logic [32:0] DAY_RCP =
        33'(((64'd1 << DAY_RCP_K) + 64'd674) / 64'd675);

    // Julian day number of 0000-01-01 folded into the date recurrences.
    localparam int JDN_YEAR0 = 1721060;
    localparam logic [24:0] A_OFFSET = 25'(4 * JDN_YEAR0 + 274277);
    localparam logic [22:0] F_OFFSET = 23'(JDN_YEAR0 + 1401 - 38);
    localparam logic [13:0] YEAR_BASE = 14'd4716;
    localparam logic [10:0] DAYS_4Y = 11'd1461;
    localparam logic [7:0] MONTH_SPAN = 8'd153;

    localparam int CENT_RCP_K = 43;
    localparam logic [25:0] CENT_RCP =
        26'(((64'd1 << CENT_RCP_K) + 64'd146096) / 64'd146097);
    localparam int QUAD_RCP_K = 36;
    localparam logic [25:0] QUAD_RCP =
        26'(((64'd1 << QUAD_RCP_K) + 64'd1460) / 64'd1461);
    localparam int MON_RCP_K = 19;
    localparam logic [11:0] MON_RCP =
        12'(((64'd1 << MON_RCP_K) + 64'd152) / 64'd153);
    localparam int FIVE_RCP_K = 11;
    localparam logic [8:0] FIVE_RCP =
        9'(((64'd1 << FIVE_RCP_K) + 64'd4) / 64'd5);

    localparam int HOUR_RCP_K = 29;
    localparam logic [17:0] HOUR_RCP =
        18'(((64'd1 << HOUR_RCP_K) + 64'd3599) / 64'd3600);
    localparam int MIN_RCP_K = 23;
    localparam logic [17:0] MIN_RCP =
        18'(((64'd1 << MIN_RCP_K) + 64'd59) / 64'd60);

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } tod_t;

endpackage

`default_nettype wire

// File: hdl/unix_seconds_to_civil_date_unit.sv
// ============================================================================
// Unix seconds to civil date unit
// Converts signed seconds since 1970-01-01T00:00:00Z to the UTC date and time.
// ============================================================================
// Usage:
// A transaction is accepted on a rising edge with start high and busy low.
// The input unix_seconds is sampled at that edge. At the end of the pipeline done is
// high for exactly one cycle with range_error, year, month, day_of_month,
// hour, minute and second; the result is taken at the edge that ends it.
// The datapath is a nine-stage pipeline in which every constant-reciprocal
// multiply ends at a register, so one transaction enters every cycle and
// throughput is one result per cycle. busy is high only while in reset and
// for the first edge after it; the unit otherwise never refuses a transaction.
// The receiver cannot stall, so no result is held back. Reset clears all
// valid bits, so transactions in flight at reset produce no result. Inputs
// outside years 0000 to 9999 give range_error high and all other result
// fields zero.
// ============================================================================
`default_nettype none
`include "unix_seconds_to_civil_date_unit_macros.svh"

module unix_seconds_to_civil_date_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [63:0] unix_seconds,
    output logic               done,
    output logic               range_error,
    output logic        [13:0] year,
    output logic        [3:0]  month,
    output logic        [4:0]  day_of_month,
    output logic        [4:0]  hour,
    output logic        [5:0]  minute,
    output logic        [5:0]  second
);

    logic       busy_reg;
    logic [8:0] valid_reg;
    logic [8:0] valid_next;
    logic [7:0] err_reg;
    logic [7:0] err_next;
    logic       in_err;

    // Stage 1
    logic [38:0] s1_u_reg;
    logic [38:0] s1_u_next;
    // Stage 2
    logic [31:0] s1_q0;
    logic [64:0] s1_prod;
    logic [21:0] s2_days_reg;
    logic [9:0]  s2_q0lo_reg;
    logic [6:0]  s2_lo7_reg;
    // Stage 3
    logic [31:0] s2_dm;
    logic [9:0]  s2_r;
    logic [16:0] s3_sod_reg;
    logic [24:0] s3_a_reg;
    logic [21:0] s3_days_reg;
    // Stage 4
    logic [50:0] s3_pa;
    logic [34:0] s3_ph;
    logic [34:0] s3_pm;
    logic [7:0]  s4_c_reg;
    logic [4:0]  s4_hour_reg;
    logic [10:0] s4_mt_reg;
    logic [16:0] s4_sod_reg;
    logic [21:0] s4_days_reg;
    // Stage 5
    logic [9:0]  s4_c3;
    logic [22:0] s4_f;
    logic [10:0] s4_mh;
    logic [10:0] s4_min_diff;
    logic [16:0] s4_ms;
    logic [16:0] s4_sec_diff;
    logic [24:0] s5_e_reg;
    ucd_pkg::tod_t s5_tod_reg;
    // Stage 6
    logic [50:0] s5_pe;
    logic [13:0] s6_y1_reg;
    logic [10:0] s6_elo_reg;
    ucd_pkg::tod_t s6_tod_reg;
    // Stage 7
    logic [24:0] s6_yd;
    logic [10:0] s6_rem;
    logic [10:0] s6_h;
    logic [10:0] s7_h_reg;
    logic [13:0] s7_y1_reg;
    ucd_pkg::tod_t s7_tod_reg;
    // Stage 8
    logic [22:0] s7_pm153;
    logic [3:0]  s7_mq;
    logic [10:0] s7_mq153;
    logic [10:0] s7_hm_diff;
    logic [3:0]  s7_month;
    logic [3:0]  s8_month_reg;
    logic [7:0]  s8_hm_reg;
    logic [13:0] s8_y1_reg;
    ucd_pkg::tod_t s8_tod_reg;
    // Output stage
    logic [16:0] s8_pd;
    logic [4:0]  s8_day;
    logic [13:0] s8_year;
    logic        range_error_reg;
    logic [13:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    ucd_pkg::tod_t tod_reg;

    // ------------------------------------------------------------------
    // Control: valid bits and range flags travel with the data.
    // ------------------------------------------------------------------
    assign in_err = (unix_seconds < ucd_pkg::LOW_LIMIT_SECS) ||
                    (unix_seconds >= ucd_pkg::HIGH_LIMIT_SECS);
    assign valid_next = {valid_reg[7:0], start && !busy_reg};
    assign err_next   = {err_reg[6:0], in_err};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            valid_reg <= '0;
        end
        else
        begin
            busy_reg  <= 1'b0;
            valid_reg <= valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Datapath combinational logic
    // ------------------------------------------------------------------
    // Shift the origin to 0000-01-01 so all floored divisions are unsigned.
    assign s1_u_next = 39'(unix_seconds + 64'(ucd_pkg::YEAR0_OFFSET));

    // Days since 0000-01-01: drop the factor of 128, then divide by 675.
    assign s1_q0   = s1_u_reg[38:7];
    assign s1_prod = 65'(s1_q0) * 65'(ucd_pkg::DAY_RCP);

    // The remainder is below 675, so ten low bits of the difference suffice.
    assign s2_dm = 32'(s2_days_reg) * 32'(ucd_pkg::DAY_ODD_FACTOR);
    assign s2_r  = s2_q0lo_reg - s2_dm[9:0];

    assign s3_pa = 51'(s3_a_reg) * 51'(ucd_pkg::CENT_RCP);
    assign s3_ph = 35'(s3_sod_reg) * 35'(ucd_pkg::HOUR_RCP);
    assign s3_pm = 35'(s3_sod_reg) * 35'(ucd_pkg::MIN_RCP);

    assign s4_c3       = 10'(s4_c_reg) * 10'd3;
    assign s4_f        = 23'(s4_days_reg) + ucd_pkg::F_OFFSET + 23'(s4_c3 >> 2);
    assign s4_mh       = 11'(s4_hour_reg) * 11'd60;
    assign s4_min_diff = s4_mt_reg - s4_mh;
    assign s4_ms       = 17'(s4_mt_reg) * 17'd60;
    assign s4_sec_diff = s4_sod_reg - s4_ms;

    assign s5_pe = 51'(s5_e_reg) * 51'(ucd_pkg::QUAD_RCP);

    // Remainder of e by 1461 fits in eleven bits.
    assign s6_yd  = 25'(s6_y1_reg) * 25'(ucd_pkg::DAYS_4Y);
    assign s6_rem = s6_elo_reg - s6_yd[10:0];
    assign s6_h   = 11'(s6_rem[10:2]) * 11'd5 + 11'd2;

    assign s7_pm153   = 23'(s7_h_reg) * 23'(ucd_pkg::MON_RCP);
    assign s7_mq      = s7_pm153[22:19];
    assign s7_mq153   = 11'(s7_mq) * 11'(ucd_pkg::MONTH_SPAN);
    assign s7_hm_diff = s7_h_reg - s7_mq153;
    // Month index counts from March; wrap the last two into January and February.
    assign s7_month   = (s7_mq >= 4'd10) ? (s7_mq - 4'd9) : (s7_mq + 4'd3);

    assign s8_pd   = 17'(s8_hm_reg) * 17'(ucd_pkg::FIVE_RCP);
    assign s8_day  = s8_pd[15:11] + 5'd1;
    assign s8_year = s8_y1_reg - ucd_pkg::YEAR_BASE + 14'(s8_month_reg <= 4'd2);

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        err_reg  <= err_next;
        s1_u_reg <= s1_u_next;

        s2_days_reg <= s1_prod[63:42];
        s2_q0lo_reg <= s1_q0[9:0];
        s2_lo7_reg  <= s1_u_reg[6:0];

        s3_sod_reg  <= {s2_r, s2_lo7_reg};
        s3_a_reg    <= 25'({s2_days_reg, 2'b00}) + ucd_pkg::A_OFFSET;
        s3_days_reg <= s2_days_reg;

        s4_c_reg    <= s3_pa[50:43];
        s4_hour_reg <= s3_ph[33:29];
        s4_mt_reg   <= s3_pm[33:23];
        s4_sod_reg  <= s3_sod_reg;
        s4_days_reg <= s3_days_reg;

        s5_e_reg          <= {s4_f, 2'b11};
        s5_tod_reg.hour   <= s4_hour_reg;
        s5_tod_reg.minute <= s4_min_diff[5:0];
        s5_tod_reg.second <= s4_sec_diff[5:0];

        s6_y1_reg  <= s5_pe[49:36];
        s6_elo_reg <= s5_e_reg[10:0];
        s6_tod_reg <= s5_tod_reg;

        s7_h_reg   <= s6_h;
        s7_y1_reg  <= s6_y1_reg;
        s7_tod_reg <= s6_tod_reg;

        s8_month_reg <= s7_month;
        s8_hm_reg    <= s7_hm_diff[7:0];
        s8_y1_reg    <= s7_y1_reg;
        s8_tod_reg   <= s7_tod_reg;

        range_error_reg <= err_reg[7];
        if (err_reg[7])
        begin
            year_reg  <= '0;
            month_reg <= '0;
            day_reg   <= '0;
            tod_reg   <= '0;
        end
        else
        begin
            year_reg  <= s8_year;
            month_reg <= s8_month_reg;
            day_reg   <= s8_day;
            tod_reg   <= s8_tod_reg;
        end
    end

    assign busy         = busy_reg;
    assign done         = valid_reg[8];
    assign range_error  = range_error_reg;
    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = day_reg;
    assign hour         = tod_reg.hour;
    assign minute       = tod_reg.minute;
    assign second       = tod_reg.second;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `UCD_ASSERT_IMP(a_fixed_latency, done, $past(start && !busy, 9), "result without matching transaction")
    `UCD_ASSERT_IMP(a_fields_in_range, done && !range_error, (month >= 4'd1) && (month <= 4'd12) && (day_of_month >= 5'd1) && (day_of_month <= 5'd31) && (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59), "result field out of range")
    `UCD_ASSERT_IMP(a_year_in_range, done && !range_error, year <= 14'd9999, "year out of range")
    `UCD_ASSERT_IMP(a_error_zeroes, done && range_error, (year == 14'd0) && (month == 4'd0) && (day_of_month == 5'd0) && (hour == 5'd0) && (minute == 6'd0) && (second == 6'd0), "fields not cleared on range error")
    `UCD_ASSERT_NXT(a_ready_after_reset, !busy, !busy, "busy raised outside reset")

endmodule

`default_nettype wire
